// ===== sv/cdfd_pkg.sv =====
// Shared types, the FNV-1a 64 prime, a basis seed and the byte fold function for the chunk digest checker.
package cdfd_pkg;

  localparam int unsigned HASH_W  = 64;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IN_TDATA_W  = 136;
  localparam int unsigned OUT_TDATA_W = 192;

  localparam logic [HASH_W-1:0] FNV_PRIME = 64'd1099511628211;
  localparam logic [HASH_W-1:0] FNV_BASIS = 64'd1469598103934665603;

  // One accepted input word, unpacked.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              last;
    logic [HASH_W-1:0] expected_hash;
    logic [HASH_W-1:0] expected_checksum;
  } item_t;

  // One closed chunk, with the expected values kept for the compare.
  typedef struct packed {
    logic [HASH_W-1:0] basis_hash;
    logic [HASH_W-1:0] chunk_checksum;
    logic [HASH_W-1:0] byte_length;
    logic [HASH_W-1:0] expected_hash;
    logic [HASH_W-1:0] expected_checksum;
  } result_t;

  // One FNV-1a step: XOR in the byte, then multiply by the prime modulo 2^64.
  // The prime is 2^40 + 0x1B3, so the product is a sum of shifted copies.
  function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// ===== sv/cdfd_in_reg.sv =====
// Input register: captures one stream word and holds it until the hash stage takes it.
module cdfd_in_reg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cdfd_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tuser,
  input  logic                               in_tlast,
  input  logic                               advance,
  output logic                               item_vld,
  output cdfd_pkg::item_t                    item
);
  import cdfd_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;

  // The register is free when empty or when its word moves on this cycle.
  assign in_tready = !vld_r || advance;
  assign vld_nxt   = in_tready ? in_tvalid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload capture, no reset needed.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.data_byte         <= in_tdata[7:0];
      item_r.expected_hash     <= in_tdata[71:8];
      item_r.expected_checksum <= in_tdata[135:72];
      item_r.has_byte          <= in_tuser;
      item_r.last              <= in_tlast;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// ===== sv/cdfd_accum.sv =====
// Hash stage: folds each byte into both running hashes and the length, and closes chunks.
module cdfd_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_vld,
  input  cdfd_pkg::item_t   item,
  input  logic              out_free,
  output logic              advance,
  output logic              res_load,
  output cdfd_pkg::result_t res
);
  import cdfd_pkg::*;

  logic [HASH_W-1:0] basis_r;
  logic [HASH_W-1:0] basis_nxt;
  logic [HASH_W-1:0] prime_r;
  logic [HASH_W-1:0] prime_nxt;
  logic [HASH_W-1:0] count_r;
  logic [HASH_W-1:0] count_nxt;
  logic [HASH_W-1:0] basis_fold;
  logic [HASH_W-1:0] prime_fold;
  logic [HASH_W-1:0] count_inc;

  // A closing word waits only when the result register is still full.
  assign advance  = item_vld && (!item.last || out_free);
  assign res_load = advance && item.last;

  // Fold the current byte when there is one.
  assign basis_fold = item.has_byte ? fnv_fold(basis_r, item.data_byte) : basis_r;
  assign prime_fold = item.has_byte ? fnv_fold(prime_r, item.data_byte) : prime_r;
  assign count_inc  = item.has_byte ? count_r + 64'd1 : count_r;

  // Closed chunk values, including the byte of the closing word.
  always_comb begin
    res.basis_hash        = basis_fold;
    res.chunk_checksum    = prime_fold ^ count_inc;
    res.byte_length       = count_inc;
    res.expected_hash     = item.expected_hash;
    res.expected_checksum = item.expected_checksum;
  end

  // Next accumulator values: hold, fold, or restart at the seeds after a close.
  always_comb begin
    basis_nxt = basis_r;
    prime_nxt = prime_r;
    count_nxt = count_r;
    if (advance) begin
      if (item.last) begin
        basis_nxt = FNV_BASIS;
        prime_nxt = FNV_PRIME;
        count_nxt = '0;
      end else begin
        basis_nxt = basis_fold;
        prime_nxt = prime_fold;
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      basis_r <= FNV_BASIS;
      prime_r <= FNV_PRIME;
      count_r <= '0;
    end else begin
      basis_r <= basis_nxt;
      prime_r <= prime_nxt;
      count_r <= count_nxt;
    end
  end

  // A closed chunk leaves all three accumulators at their seeds.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (basis_r == FNV_BASIS && prime_r == FNV_PRIME && count_r == '0))
    else $error("accumulators not restarted after a closed chunk");

  // A byte in a non-closing word bumps the length by exactly one.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && item.has_byte && !item.last) |=> (count_r == $past(count_r) + 64'd1))
    else $error("byte count did not advance by one");

  // A word without a byte and without last leaves the hashes untouched.
  a_idle_word: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !item.has_byte && !item.last) |=>
      (basis_r == $past(basis_r) && prime_r == $past(prime_r)))
    else $error("hash changed on a word without a byte");

endmodule

// ===== sv/cdfd_out_reg.sv =====
// Result register: holds one closed chunk for the output stream and forms the match flag.
module cdfd_out_reg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               res_load,
  input  cdfd_pkg::result_t                  res,
  output logic                               out_free,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cdfd_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tuser
);
  import cdfd_pkg::*;

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  assign out_free = !vld_r || out_tready;
  assign vld_nxt  = res_load || (vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  // Pack the word and compare against the expected values held with it.
  assign out_tvalid = vld_r;
  assign out_tdata  = {res_r.byte_length, res_r.chunk_checksum, res_r.basis_hash};
  assign out_tuser  = (res_r.basis_hash == res_r.expected_hash) &&
                      (res_r.chunk_checksum == res_r.expected_checksum);

  // A new result is loaded only into a free register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> out_free)
    else $error("result register overwritten while full");

endmodule

// ===== sv/chunk_dual_fnv_digest_check.sv =====
// Top level of the chunk digest checker: two hashes by the FNV-1a 64 fold and a length per chunk.
//
//  channel  direction  tdata                                          tuser      tlast
//  in_      slave      data_byte, expected_hash, expected_checksum    has_byte   last
//  out_     master     basis_hash, chunk_checksum, byte_length        match      -
//
// One input word is taken every cycle unless a closing word waits for the result register;
// the combinational byte fold of the two hashes and the length counter is the loop that sets it.
// A closing word is registered in the input register and then in the result register,
// whose valid bit drives out_tvalid; only then can its result be taken on out_.
// Reset is synchronous, active low; it empties both registers and reseeds the hashes.
// While the output is stalled, words without last keep flowing; a closing word
// waits in the input register until the result register is free.
module chunk_dual_fnv_digest_check (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] data_byte, [71:8] expected_hash, [135:72] expected_checksum
  input  logic [cdfd_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] has_byte
  input  logic                               in_tuser,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [63:0] basis_hash, [127:64] chunk_checksum, [191:128] byte_length
  output logic [cdfd_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] match
  output logic                               out_tuser
);
  import cdfd_pkg::*;

  logic    item_vld;
  item_t   item;
  logic    advance;
  logic    out_free;
  logic    res_load;
  result_t res;

  cdfd_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .advance   (advance),
    .item_vld  (item_vld),
    .item      (item)
  );

  cdfd_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (item_vld),
    .item     (item),
    .out_free (out_free),
    .advance  (advance),
    .res_load (res_load),
    .res      (res)
  );

  cdfd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_load   (res_load),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // A closing word blocked by a full result register also blocks the input.
  a_close_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld && item.last && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while a closing word is stalled");

  // Nothing is offered on the output in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule
